// ===== rtl/core/doubly_linked_list_manager_core_macros.svh =====
// Assertion helpers for the linked list manager; every check is clocked on clk
// and held off while rst_n is low.
`ifndef DOUBLY_LINKED_LIST_MANAGER_CORE_MACROS_SVH
`define DOUBLY_LINKED_LIST_MANAGER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define DLLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DLLM_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define DLLM_ASSERT(lbl, prop, msg)
`define DLLM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/dllm_pkg.sv =====
`default_nettype none

package dllm_pkg;

  localparam int POOL_NODES   = 1024;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(POOL_NODES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CMD_W        = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AFTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_NODE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_NODE    = 3'd5;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic                    next_we;
    logic [IDX_W-1:0]        next_addr;
    link_t                   next_data;
    logic                    prev_we;
    logic [IDX_W-1:0]        prev_addr;
    link_t                   prev_data;
    logic                    pay_we;
    logic [IDX_W-1:0]        pay_addr;
    logic [PAYLOAD_BITS-1:0] pay_data;
  } store_wr_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } store_rd_t;

  typedef struct packed {
    link_t                   next;
    link_t                   prev;
    logic [PAYLOAD_BITS-1:0] pay;
  } store_rdata_t;

endpackage

`default_nettype wire

// ===== rtl/core/dllm_store.sv =====
`default_nettype none

module dllm_store import dllm_pkg::*; (
  input  logic         clk,
  input  store_wr_t    wr,
  input  store_rd_t    rd,
  output store_rdata_t rd_data
);

  link_t                   next_mem [POOL_NODES];
  link_t                   prev_mem [POOL_NODES];
  logic [PAYLOAD_BITS-1:0] pay_mem  [POOL_NODES];
  store_rdata_t            rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
    if (wr.pay_we) begin
      pay_mem[wr.pay_addr] <= wr.pay_data;
    end
  end

  // one node per read: both links and the payload come back together
  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      rd_data_r.next <= next_mem[rd.rd_addr];
      rd_data_r.prev <= prev_mem[rd.rd_addr];
      rd_data_r.pay  <= pay_mem[rd.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/doubly_linked_list_manager_core.sv =====
// Sequence: accept, then evaluate; read_node, clear and errors go on to done, remove_after
// and remove_node pass S_WR1 first, and inserts pass S_WR1 and S_WR2 first.
// A new command is taken in the cycle after the result is handed to the output register,
// so none is taken while the last one is in flight or its result waits for the output to drain;
// inserts need both write states, as the single write port of each node memory is shared under the sequencer.
// Reset clears head, tail, count and the sequencer; node memories start undefined.
`default_nettype none
`include "doubly_linked_list_manager_core_macros.svh"

module doubly_linked_list_manager_core import dllm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic                    in_anchor_none,
  input  logic [IDX_W-1:0]        in_anchor_node,
  input  logic [IDX_W-1:0]        in_container_node,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_status,
  output logic [PAYLOAD_BITS-1:0] out_payload_out,
  output logic [CNT_W-1:0]        out_list_count,
  output logic                    out_head_valid,
  output logic [IDX_W-1:0]        out_head_index,
  output logic                    out_tail_valid,
  output logic [IDX_W-1:0]        out_tail_index,
  output logic                    out_read_next_valid,
  output logic [IDX_W-1:0]        out_read_next,
  output logic                    out_read_prev_valid,
  output logic [IDX_W-1:0]        out_read_prev
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_WR1  = 5'b00100,
    S_WR2  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  link_t                   head_r, head_nxt;
  link_t                   tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic                    none_r, none_nxt;
  logic [IDX_W-1:0]        anc_idx_r, anc_idx_nxt;
  logic [IDX_W-1:0]        cont_r, cont_nxt;
  logic [PAYLOAD_BITS-1:0] data_r, data_nxt;
  link_t                   anc_r, anc_nxt;
  link_t                   succ_r, succ_nxt;
  logic                    status_r, status_nxt;
  logic [PAYLOAD_BITS-1:0] payo_r, payo_nxt;
  link_t                   rn_r, rn_nxt;
  link_t                   rp_r, rp_nxt;

  logic                    o_status_r;
  logic [PAYLOAD_BITS-1:0] o_pay_r;
  logic [CNT_W-1:0]        o_count_r;
  link_t                   o_head_r, o_tail_r, o_rn_r, o_rp_r;

  store_wr_t               wr;
  store_rd_t               rd;
  store_rdata_t            rdata;
  logic                    accept;
  logic                    load_out;
  logic                    empty;
  logic                    full;
  logic                    mem_we;
  link_t                   ins_anchor;
  link_t                   cont_link;
  link_t                   anc_link;

  dllm_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign empty     = (count_r == '0) || !head_r.valid;
  assign full      = (count_r == CNT_W'(POOL_NODES));
  assign mem_we    = wr.next_we || wr.prev_we || wr.pay_we;
  assign cont_link = '{valid: 1'b1, idx: cont_r};
  assign anc_link  = '{valid: 1'b1, idx: anc_idx_r};

  always_comb begin
    if (cmd_r == CMD_INSERT_AFTER) begin
      ins_anchor = none_r ? link_t'('0) : anc_link;
    end else begin
      ins_anchor = tail_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_nxt       = cmd_r;
    none_nxt      = none_r;
    anc_idx_nxt   = anc_idx_r;
    cont_nxt      = cont_r;
    data_nxt      = data_r;
    anc_nxt       = anc_r;
    succ_nxt      = succ_r;
    status_nxt    = status_r;
    payo_nxt      = payo_r;
    rn_nxt        = rn_r;
    rp_nxt        = rp_r;
    wr            = '0;
    rd.rd_en      = 1'b0;
    rd.rd_addr    = in_anchor_node;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          none_nxt    = in_anchor_none;
          anc_idx_nxt = in_anchor_node;
          cont_nxt    = in_container_node;
          data_nxt    = in_payload;
          status_nxt  = STATUS_OK;
          payo_nxt    = '0;
          rn_nxt      = '0;
          rp_nxt      = '0;
          rd.rd_en    = 1'b1;
          if (in_cmd == CMD_REMOVE_AFTER && in_anchor_none) begin
            rd.rd_addr = head_r.idx;
          end else if (in_cmd == CMD_APPEND) begin
            rd.rd_addr = tail_r.idx;
          end
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        state_nxt = S_DONE;
        case (cmd_r) inside
          CMD_INSERT_AFTER, CMD_APPEND: begin
            if (full) begin
              status_nxt = STATUS_ERR;
            end else begin
              anc_nxt   = ins_anchor;
              succ_nxt  = ins_anchor.valid ? rdata.next : head_r;
              state_nxt = S_WR1;
            end
          end
          CMD_REMOVE_AFTER: begin
            if (empty) begin
              status_nxt = STATUS_ERR;
            end else if (none_r) begin
              state_nxt = S_WR1;
            end else if (!rdata.next.valid) begin
              status_nxt = STATUS_ERR;
            end else begin
              // fetch the node being unlinked
              rd.rd_en   = 1'b1;
              rd.rd_addr = rdata.next.idx;
              state_nxt  = S_WR1;
            end
          end
          CMD_REMOVE_NODE: begin
            if (none_r || empty) begin
              status_nxt = STATUS_ERR;
            end else begin
              state_nxt = S_WR1;
            end
          end
          CMD_CLEAR: begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
          end
          CMD_READ_NODE: begin
            if (none_r) begin
              status_nxt = STATUS_ERR;
            end else begin
              payo_nxt = rdata.pay;
              rn_nxt   = rdata.next;
              rp_nxt   = rdata.prev;
            end
          end
          default: begin
            status_nxt = STATUS_ERR;
          end
        endcase
      end

      S_WR1: begin
        state_nxt = S_DONE;
        case (cmd_r) inside
          CMD_INSERT_AFTER, CMD_APPEND: begin
            wr.pay_we    = 1'b1;
            wr.pay_addr  = cont_r;
            wr.pay_data  = data_r;
            wr.next_we   = 1'b1;
            wr.next_addr = cont_r;
            wr.next_data = succ_r;
            wr.prev_we   = succ_r.valid;
            wr.prev_addr = succ_r.idx;
            wr.prev_data = cont_link;
            state_nxt    = S_WR2;
          end
          CMD_REMOVE_AFTER: begin
            payo_nxt     = rdata.pay;
            wr.prev_addr = rdata.next.idx;
            wr.prev_we   = rdata.next.valid;
            if (none_r) begin
              head_nxt     = rdata.next;
              wr.prev_data = '0;
              if (!rdata.next.valid) begin
                tail_nxt = '0;
              end
            end else begin
              wr.next_we   = 1'b1;
              wr.next_addr = anc_idx_r;
              wr.next_data = rdata.next;
              wr.prev_data = anc_link;
              if (!rdata.next.valid) begin
                tail_nxt = anc_link;
              end
            end
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end
          end
          CMD_REMOVE_NODE: begin
            payo_nxt     = rdata.pay;
            wr.prev_we   = rdata.next.valid;
            wr.prev_addr = rdata.next.idx;
            wr.prev_data = rdata.prev;
            wr.next_we   = rdata.prev.valid;
            wr.next_addr = rdata.prev.idx;
            wr.next_data = rdata.next;
            if (!rdata.next.valid) begin
              tail_nxt = rdata.prev;
            end
            if (!rdata.prev.valid) begin
              head_nxt = rdata.next;
            end
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end

      S_WR2: begin
        // link the new node behind its anchor, or make it the head
        wr.next_we   = anc_r.valid;
        wr.next_addr = anc_r.idx;
        wr.next_data = cont_link;
        wr.prev_we   = 1'b1;
        wr.prev_addr = cont_r;
        wr.prev_data = anc_r;
        if (!anc_r.valid) begin
          head_nxt = cont_link;
        end
        if (!succ_r.valid) begin
          tail_nxt = cont_link;
        end
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    none_r    <= none_nxt;
    anc_idx_r <= anc_idx_nxt;
    cont_r    <= cont_nxt;
    data_r    <= data_nxt;
    anc_r     <= anc_nxt;
    succ_r    <= succ_nxt;
    status_r  <= status_nxt;
    payo_r    <= payo_nxt;
    rn_r      <= rn_nxt;
    rp_r      <= rp_nxt;
  end

  // capture the result on load_out, dropping the index of any link that is not valid
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r <= status_r;
      o_pay_r    <= payo_r;
      o_count_r  <= count_r;
      o_head_r   <= head_r.valid ? head_r : link_t'('0);
      o_tail_r   <= tail_r.valid ? tail_r : link_t'('0);
      o_rn_r     <= rn_r.valid ? rn_r : link_t'('0);
      o_rp_r     <= rp_r.valid ? rp_r : link_t'('0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_payload_out     = o_pay_r;
  assign out_list_count      = o_count_r;
  assign out_head_valid      = o_head_r.valid;
  assign out_head_index      = o_head_r.idx;
  assign out_tail_valid      = o_tail_r.valid;
  assign out_tail_index      = o_tail_r.idx;
  assign out_read_next_valid = o_rn_r.valid;
  assign out_read_next       = o_rn_r.idx;
  assign out_read_prev_valid = o_rp_r.valid;
  assign out_read_prev       = o_rp_r.idx;

  `DLLM_ASSERT(a_state_onehot, $onehot(state_r), "sequencer state is not one-hot")
  `DLLM_ASSERT(a_count_range, count_r <= CNT_W'(POOL_NODES), "node count above pool size")
  `DLLM_ASSERT(a_write_step, mem_we |-> (state_r == S_WR1 || state_r == S_WR2), "stray write")
  `DLLM_ASSERT_NEXT(a_accept_to_eval, accept, state_r == S_EVAL, "accept skipped evaluation")
  `DLLM_ASSERT(a_result_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "early result")

endmodule

`default_nettype wire
